FILE: hw/rtl/tdpt_pkg.sv
// Shared constants and types for the trial-division prime test core.
// No dependencies; imported by every module of the core.
`default_nettype none

package tdpt_pkg;

  localparam int NUMBER_WIDTH_DEF = 32;
  localparam int FIFO_DEPTH       = 2;

  // Front-end verdict carried with each queued item
  typedef enum logic [1:0] {
    CLS_NOT_PRIME = 2'b00,
    CLS_PRIME     = 2'b01,
    CLS_TEST      = 2'b10
  } tdpt_cls_t;

  localparam int CLS_W = $bits(tdpt_cls_t);

endpackage

`default_nettype wire

FILE: hw/rtl/tdpt_front.sv
// Front end: classifies each incoming number so only odd values of five or more
// need trial division. Depends on tdpt_pkg.
`default_nettype none

module tdpt_front #(
  parameter int NUMBER_WIDTH = 32
) (
  input  wire logic signed [NUMBER_WIDTH-1:0] candidate,
  output tdpt_pkg::tdpt_cls_t                 cls
);
  import tdpt_pkg::*;

  logic neg;
  logic zero_or_one;
  logic two_or_three;
  logic even;

  assign neg          = candidate[NUMBER_WIDTH-1];
  assign zero_or_one  = (candidate[NUMBER_WIDTH-1:1] == '0);
  assign two_or_three = (candidate[NUMBER_WIDTH-1:2] == '0) && candidate[1];
  assign even         = !candidate[0];

  always_comb begin
    if (neg || zero_or_one) begin
      cls = CLS_NOT_PRIME;
    end else if (two_or_three) begin
      cls = CLS_PRIME;
    end else if (even) begin
      cls = CLS_NOT_PRIME;
    end else begin
      cls = CLS_TEST;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tdpt_fifo.sv
// Short register queue between the front end and the trial-division engine.
// Depends on tdpt_pkg for its depth.
`default_nettype none

module tdpt_fifo #(
  parameter int DATA_W = 34
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic [DATA_W-1:0]      head_data,
  output logic                   empty
);
  import tdpt_pkg::*;

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic [DATA_W-1:0] mem_r [FIFO_DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r,  count_nxt;
  logic              do_push, do_pop;

  assign full      = (count_r == CW'(FIFO_DEPTH));
  assign empty     = (count_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tdpt_back.sv
// Back end: odd trial divisors with a one-bit-per-cycle remainder unit and an
// incrementally kept divisor square; holds one result for the consumer. Uses tdpt_pkg.
`default_nettype none

module tdpt_back #(
  parameter int NUMBER_WIDTH = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    q_empty,
  input  tdpt_pkg::tdpt_cls_t          q_cls,
  input  wire logic [NUMBER_WIDTH-1:0] q_num,
  output logic                         q_pop,
  output logic                         out_empty,
  input  wire logic                    out_pop,
  output logic                         out_is_prime
);
  import tdpt_pkg::*;

  localparam int DW  = NUMBER_WIDTH / 2 + 1;   // divisor and remainder
  localparam int SQW = NUMBER_WIDTH + 1;       // divisor square
  localparam int CW  = $clog2(NUMBER_WIDTH);   // dividend bit index

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t                  st_r, st_nxt;
  logic [NUMBER_WIDTH-1:0] n_r, n_nxt;
  logic [DW-1:0]           d_r, d_nxt;
  logic [SQW-1:0]          sq_r, sq_nxt;
  logic [DW-1:0]           rem_r, rem_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic                    res_r, res_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_r, out_nxt;

  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic [DW-1:0] rem_step;
  logic          out_free;

  assign shifted  = {rem_r, n_r[cnt_r]};
  assign diff     = shifted - {1'b0, d_r};
  assign rem_step = (shifted >= {1'b0, d_r}) ? diff[DW-1:0] : shifted[DW-1:0];
  assign out_free = !out_valid_r || out_pop;

  assign q_pop        = (st_r == ST_IDLE) && !q_empty;
  assign out_empty    = !out_valid_r;
  assign out_is_prime = out_r;

  always_comb begin
    st_nxt        = st_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_nxt       = out_r;
    unique case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          n_nxt  = q_num;
          d_nxt  = DW'(3);
          sq_nxt = SQW'(9);
          unique case (q_cls)
            CLS_PRIME: begin
              res_nxt = 1'b1;
              st_nxt  = ST_DONE;
            end
            CLS_TEST: begin
              st_nxt = ST_CHECK;
            end
            default: begin
              res_nxt = 1'b0;
              st_nxt  = ST_DONE;
            end
          endcase
        end
      end
      ST_CHECK: begin
        if (sq_r > {1'b0, n_r}) begin
          res_nxt = 1'b1;
          st_nxt  = ST_DONE;
        end else begin
          rem_nxt = '0;
          cnt_nxt = CW'(NUMBER_WIDTH - 1);
          st_nxt  = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          if (rem_step == '0) begin
            res_nxt = 1'b0;
            st_nxt  = ST_DONE;
          end else begin
            // advance to the next odd divisor: (d+2)^2 = d^2 + 4d + 4
            d_nxt  = d_r + DW'(2);
            sq_nxt = sq_r + SQW'({d_r, 2'b00}) + SQW'(4);
            st_nxt = ST_CHECK;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    sq_r  <= sq_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/trial_division_prime_test_core.sv
// Trial-division prime test: one signed number in, one prime flag out.
// Non-positive, one, two, three and even numbers skip trial division and pass from the queue to the result register.
// Odd n >= 5: each odd divisor d = 3, 5, ... with d*d <= n gets a check step and a division pass through
// the shared one-bit-per-cycle remainder unit; a zero remainder means not prime.
// Items are taken one at a time by the engine; a two-entry queue and a result register decouple.
// Synchronous active-low reset clears queue, sequencer and result flag; no clearing pass.
`default_nettype none

module trial_division_prime_test_core #(
  parameter int NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_push,
  output logic                                in_full,
  input  wire logic signed [NUMBER_WIDTH-1:0] in_candidate,
  output logic                                out_empty,
  input  wire logic                           out_pop,
  output logic                                out_is_prime
);
  import tdpt_pkg::*;

  localparam int QW = CLS_W + NUMBER_WIDTH;

  tdpt_cls_t         front_cls;
  logic [QW-1:0]     q_wdata;
  logic [QW-1:0]     q_rdata;
  logic              q_empty;
  logic              q_pop;
  tdpt_cls_t         q_cls;

  tdpt_front #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_front (
    .candidate (in_candidate),
    .cls       (front_cls)
  );

  assign q_wdata = {front_cls, in_candidate};

  tdpt_fifo #(
    .DATA_W (QW)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_data (q_wdata),
    .full      (in_full),
    .pop       (q_pop),
    .head_data (q_rdata),
    .empty     (q_empty)
  );

  assign q_cls = tdpt_cls_t'(q_rdata[QW-1:NUMBER_WIDTH]);

  tdpt_back #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_cls        (q_cls),
    .q_num        (q_rdata[NUMBER_WIDTH-1:0]),
    .q_pop        (q_pop),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_is_prime (out_is_prime)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/tdpt_checker.sv
// Port-level checker for the prime test core, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module tdpt_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_push,
  input wire logic in_full,
  input wire logic out_empty,
  input wire logic out_pop,
  input wire logic out_is_prime
);

  // items accepted and not yet popped: at most queue + engine + result register
  logic [3:0] pending_r;
  logic       acc_in, acc_out;

  assign acc_in  = in_push && !in_full;
  assign acc_out = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (acc_in && !acc_out) begin
      pending_r <= pending_r + 1'b1;
    end else if (acc_out && !acc_in) begin
      pending_r <= pending_r - 1'b1;
    end
  end

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not cleared by reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> pending_r != 4'd0)
    else $error("result shown with no item pending");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 4'd4)
    else $error("more items pending than the core can hold");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_is_prime))
    else $error("waiting result changed or dropped");

endmodule

bind trial_division_prime_test_core tdpt_checker u_tdpt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_push      (in_push),
  .in_full      (in_full),
  .out_empty    (out_empty),
  .out_pop      (out_pop),
  .out_is_prime (out_is_prime)
);

`default_nettype wire
